// File: design/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg - shared types and constants for the bitmap block allocator
// Field widths, mode and status codes, scan result bundle.
// ----------------------------------------------------------------------------
package bba_pkg;

   // fixed field widths
   localparam int MODE_W    = 2;
   localparam int BLK_W     = 10;
   localparam int STATUS_W  = 2;
   localparam int NB_W      = 11;   // num_blocks register width

   // bitmap word geometry
   localparam int WORD_W    = 32;
   localparam int BIT_W     = 5;

   // parameter defaults
   localparam int DEF_MAX_BLOCKS            = 1024;
   localparam int DEF_BITS_PER_BITMAP_BLOCK = 32768;
   localparam int NUM_BLOCKS_RESET          = 1024;

   // request modes
   localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

   // response status
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_FREE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

   typedef struct packed {
      logic             found;
      logic [BIT_W-1:0] bit_idx;
   } scan_res_type;

endpackage

// File: design/bba_req_if.sv
// ----------------------------------------------------------------------------
// bba_req_if - request channel
// One beat carries a mode and a block number.
// ----------------------------------------------------------------------------
interface bba_req_if;
   import bba_pkg::*;

   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [BLK_W-1:0]  block_number;

   modport source (output valid, output mode, output block_number, input ready);
   modport sink   (input valid, input mode, input block_number, output ready);

endinterface

// File: design/bba_rsp_if.sv
// ----------------------------------------------------------------------------
// bba_rsp_if - response channel
// One beat per request: status, granted block, query flag.
// ----------------------------------------------------------------------------
interface bba_rsp_if;
   import bba_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [BLK_W-1:0]    allocated_block;
   logic                free_flag;

   modport source (output valid, output status, output allocated_block,
                   output free_flag, input ready);
   modport sink   (input valid, input status, input allocated_block,
                   input free_flag, output ready);

endinterface

// File: design/bba_csr_if.sv
// ----------------------------------------------------------------------------
// bba_csr_if - configuration write channel
// One beat writes the num_blocks register.
// ----------------------------------------------------------------------------
interface bba_csr_if;
   import bba_pkg::*;

   logic            valid;
   logic            ready;
   logic [NB_W-1:0] num_blocks;

   modport source (output valid, output num_blocks, input ready);
   modport sink   (input valid, input num_blocks, output ready);

endinterface

// File: design/bba_scan_unit.sv
// ----------------------------------------------------------------------------
// bba_scan_unit - first-set search over one bitmap word
// Masks bits outside the search window, then finds the lowest set bit.
// ----------------------------------------------------------------------------
module bba_scan_unit #(
   parameter int AW = 5
) (
   input  logic [bba_pkg::WORD_W-1:0] word_data,
   input  logic [AW-1:0]              word_idx,
   input  logic [AW-1:0]              first_word,
   input  logic [bba_pkg::BIT_W-1:0]  first_bit,
   input  logic [AW-1:0]              last_word,
   input  logic [bba_pkg::BIT_W-1:0]  last_bit,
   output bba_pkg::scan_res_type      res
);
   import bba_pkg::*;

   logic [WORD_W-1:0] lo_mask;
   logic [WORD_W-1:0] hi_mask;
   logic [WORD_W-1:0] cand;

   always_comb begin
      lo_mask = (word_idx == first_word) ? ({WORD_W{1'b1}} << first_bit) : {WORD_W{1'b1}};
      hi_mask = (word_idx == last_word)
              ? ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - last_bit)) : {WORD_W{1'b1}};
      cand    = word_data & lo_mask & hi_mask;
      res.found   = |cand;
      res.bit_idx = '0;
      // lowest set bit wins
      for (int b = WORD_W - 1; b >= 0; b--) begin
         if (cand[b]) begin
            res.bit_idx = BIT_W'(b);
         end
      end
   end

endmodule

// File: design/bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator - first-fit free-block bitmap
// Allocate: a launch from idle, then one bitmap word per cycle up to the
//   window's last word, plus a response beat. Free / query: a word read,
//   then a write-back or bit test; invalid numbers, unused modes answer from idle.
// One request at a time; the next is taken after the response beat leaves.
// Reset: a clearing pass writes all MAP_WORDS words to zero; num_blocks returns
//   to 1024. A num_blocks write takes effect on its own beat, search start
//   included; it never stalls.
// ----------------------------------------------------------------------------
module bitmap_block_allocator #(
   parameter int MAX_BLOCKS            = bba_pkg::DEF_MAX_BLOCKS,
   parameter int BITS_PER_BITMAP_BLOCK = bba_pkg::DEF_BITS_PER_BITMAP_BLOCK
) (
   input  logic       clock,
   input  logic       reset,
   bba_req_if.sink    req_chan,
   bba_rsp_if.source  rsp_chan,
   bba_csr_if.sink    csr_chan
);
   import bba_pkg::*;

   // geometry of the bitmap store
   localparam int MAP_WORDS = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
   localparam int AW        = $clog2(MAP_WORDS);

   // block limit never exceeds what num_blocks can express
   localparam int NB_MAX  = (1 << NB_W) - 1;
   localparam int LIM_CAP = (MAX_BLOCKS > NB_MAX) ? NB_MAX : MAX_BLOCKS;

   // search start: num_blocks / BITS_PER_BITMAP_BLOCK by reciprocal multiply.
   // With shift NB_W + ceil(log2 d) and a rounded-up reciprocal the quotient
   // is exact for every NB_W-bit num_blocks.
   localparam int DIV_SH      = NB_W + $clog2(BITS_PER_BITMAP_BLOCK);
   localparam int DIV_RCP     = ((1 << DIV_SH) + BITS_PER_BITMAP_BLOCK - 1)
                                / BITS_PER_BITMAP_BLOCK;
   localparam int RCP_W       = NB_W + 2;
   localparam int PROD_W      = NB_W + RCP_W;
   localparam int START_RESET = 2 + NUM_BLOCKS_RESET / BITS_PER_BITMAP_BLOCK;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_ALLOC,
      S_RMW
   } state_type;

   // ---------------------------------------------------------------- config
   logic [NB_W-1:0]   num_blocks_ff;
   logic [NB_W-1:0]   start_ff;
   logic [NB_W-1:0]   start_in;
   logic [PROD_W-1:0] start_prod;
   logic              csr_fire;

   // --------------------------------------------------------------- control
   state_type         state_ff, state_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic [AW-1:0]     scan_w_ff, scan_w_in;     // word whose data is checked now
   logic [AW-1:0]     issue_w_ff, issue_w_in;   // word being read ahead
   logic [BLK_W-1:0]  blk_ff, blk_in;
   logic              is_free_ff, is_free_in;

   // response holding register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [BLK_W-1:0]    rsp_block_ff, rsp_block_in;
   logic                rsp_flag_ff, rsp_flag_in;

   // bitmap store ports
   logic [WORD_W-1:0] map_mem [MAP_WORDS];
   logic [WORD_W-1:0] rd_data_ff;
   logic [AW-1:0]     rd_addr;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [WORD_W-1:0] wr_data;

   // derived search window
   logic [NB_W-1:0]   lim;
   logic [NB_W-1:0]   last_blk;
   logic [AW-1:0]     start_w;
   logic [AW-1:0]     last_w;
   logic              no_range;
   logic [NB_W-1:0]   req_blk_ext;
   logic [AW-1:0]     req_word;
   logic [BIT_W-1:0]  rmw_bit;
   logic              req_fire;
   logic              rsp_take;
   scan_res_type      scan_res;

   // ------------------------------------------------------ search start calc
   // Start = 2 + quotient (superblock, boot block, then the bitmap blocks).
   assign csr_fire       = csr_chan.valid && csr_chan.ready;
   assign csr_chan.ready = 1'b1;

   always_comb begin
      start_prod = PROD_W'(csr_chan.num_blocks) * PROD_W'(DIV_RCP);
      start_in   = NB_W'(start_prod >> DIV_SH) + NB_W'(2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_blocks_ff <= NB_W'(NUM_BLOCKS_RESET);
         start_ff      <= NB_W'(START_RESET);
      end else if (csr_fire) begin
         num_blocks_ff <= csr_chan.num_blocks;
         start_ff      <= start_in;
      end
   end

   // ---------------------------------------------------------- search window
   always_comb begin
      lim         = (num_blocks_ff > NB_W'(LIM_CAP)) ? NB_W'(LIM_CAP) : num_blocks_ff;
      last_blk    = lim - NB_W'(1);
      start_w     = AW'(start_ff[NB_W-1:BIT_W]);
      last_w      = AW'(last_blk[NB_W-1:BIT_W]);
      no_range    = (start_ff >= lim);
      req_blk_ext = NB_W'(req_chan.block_number);
      req_word    = AW'(req_chan.block_number[BLK_W-1:BIT_W]);
      rmw_bit     = blk_ff[BIT_W-1:0];
   end

   // allocation word search: masks the window edges, finds first free bit
   bba_scan_unit #(
      .AW (AW)
   ) u_scan (
      .word_data  (rd_data_ff),
      .word_idx   (scan_w_ff),
      .first_word (start_w),
      .first_bit  (start_ff[BIT_W-1:0]),
      .last_word  (last_w),
      .last_bit   (last_blk[BIT_W-1:0]),
      .res        (scan_res)
   );

   // ------------------------------------------------------------- sequencer
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_take       = rsp_chan.valid && rsp_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE) && !rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      scan_w_in     = scan_w_ff;
      issue_w_in    = issue_w_ff;
      blk_in        = blk_ff;
      is_free_in    = is_free_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_take;
      rsp_status_in = rsp_status_ff;
      rsp_block_in  = rsp_block_ff;
      rsp_flag_in   = rsp_flag_ff;
      rd_addr       = issue_w_ff;
      wr_en         = 1'b0;
      wr_addr       = clr_ff;
      wr_data       = '0;

      case (state_ff)
         S_CLEAR: begin
            // zero one word per cycle: every block starts out in use
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            if (clr_ff == AW'(MAP_WORDS - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + AW'(1);
            end
         end

         S_IDLE: begin
            if (req_fire) begin
               blk_in     = req_chan.block_number;
               is_free_in = (req_chan.mode == MODE_FREE);
               case (req_chan.mode)
                  MODE_ALLOC: begin
                     if (no_range) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_NO_FREE;
                        rsp_block_in  = '0;
                        rsp_flag_in   = 1'b0;
                     end else begin
                        rd_addr    = start_w;
                        scan_w_in  = start_w;
                        issue_w_in = start_w + AW'(1);
                        state_in   = S_ALLOC;
                     end
                  end
                  MODE_FREE: begin
                     // block zero and blocks at or past the limit are refused
                     if (req_chan.block_number == '0 || req_blk_ext >= lim) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_INVALID;
                        rsp_block_in  = '0;
                        rsp_flag_in   = 1'b0;
                     end else begin
                        rd_addr  = req_word;
                        state_in = S_RMW;
                     end
                  end
                  MODE_QUERY: begin
                     if (req_blk_ext >= lim) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_INVALID;
                        rsp_block_in  = '0;
                        rsp_flag_in   = 1'b0;
                     end else begin
                        rd_addr  = req_word;
                        state_in = S_RMW;
                     end
                  end
                  default: begin
                     // unused mode: no state change, all-zero response
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_OK;
                     rsp_block_in  = '0;
                     rsp_flag_in   = 1'b0;
                  end
               endcase
            end
         end

         S_ALLOC: begin
            // rd_data_ff holds word scan_w_ff; the next word is already in flight
            rd_addr = issue_w_ff;
            if (scan_res.found) begin
               wr_en         = 1'b1;
               wr_addr       = scan_w_ff;
               wr_data       = rd_data_ff & ~(WORD_W'(1) << scan_res.bit_idx);
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_block_in  = BLK_W'({scan_w_ff, scan_res.bit_idx});
               rsp_flag_in   = 1'b0;
               state_in      = S_IDLE;
            end else if (scan_w_ff == last_w) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_NO_FREE;
               rsp_block_in  = '0;
               rsp_flag_in   = 1'b0;
               state_in      = S_IDLE;
            end else begin
               scan_w_in  = scan_w_ff + AW'(1);
               issue_w_in = issue_w_ff + AW'(1);
            end
         end

         S_RMW: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_OK;
            rsp_block_in  = '0;
            if (is_free_ff) begin
               wr_en       = 1'b1;
               wr_addr     = AW'(blk_ff[BLK_W-1:BIT_W]);
               wr_data     = rd_data_ff | (WORD_W'(1) << rmw_bit);
               rsp_flag_in = 1'b0;
            end else begin
               rsp_flag_in = rd_data_ff[rmw_bit];
            end
            state_in = S_IDLE;
         end

         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_w_ff     <= scan_w_in;
      issue_w_ff    <= issue_w_in;
      blk_ff        <= blk_in;
      is_free_ff    <= is_free_in;
      rsp_status_ff <= rsp_status_in;
      rsp_block_ff  <= rsp_block_in;
      rsp_flag_ff   <= rsp_flag_in;
   end

   // ---------------------------------------------------------- bitmap store
   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= map_mem[rd_addr];
   end

   // --------------------------------------------------------- response beat
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.status          = rsp_status_ff;
   assign rsp_chan.allocated_block = rsp_block_ff;
   assign rsp_chan.free_flag       = rsp_flag_ff;

   // ------------------------------------------------------------ assertions
   // a granted block lies inside [start, limit)
   a_grant_in_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ALLOC && scan_res.found) |->
         (NB_W'({scan_w_ff, scan_res.bit_idx}) >= start_ff &&
          NB_W'({scan_w_ff, scan_res.bit_idx}) < lim))
      else $error("allocator granted a block outside the search window");

   // the word scan never leaves the window's words
   a_scan_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ALLOC) |-> (scan_w_ff >= start_w && scan_w_ff <= last_w))
      else $error("word scan ran outside the search window");

   // no response can appear while the store is being cleared
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !rsp_valid_ff)
      else $error("response pending during clearing pass");

endmodule
